@@ src/sparse_row_product_accumulator_top_assert.svh @@
// assertion macros for the row accumulator
`ifndef SPARSE_ROW_PRODUCT_ACCUMULATOR_TOP_ASSERT_SVH
`define SPARSE_ROW_PRODUCT_ACCUMULATOR_TOP_ASSERT_SVH

// same-cycle implication
`define SRPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srpa assertion failed");

// next-cycle implication
`define SRPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srpa assertion failed");

`endif

@@ src/srpa_pkg.sv @@
package srpa_pkg;

  localparam int ROW_CAPACITY_DEF = 64;
  localparam int COLUMN_BITS_DEF  = 16;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic MODE_ORDINARY = 1'b0;
  localparam logic MODE_FILTER   = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] a_weight;
    logic        [15:0] b_col;
    logic signed [15:0] b_weight;
  } in_data_t;

  typedef struct packed {
    logic        [15:0] out_col;
    logic signed [31:0] out_weight;
    logic               last;
    logic               empty_res;
    logic               overflow;
  } out_data_t;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic val_en;
    logic idx_clr;
    logic idx_inc;
    logic wr_match;
    logic wr_append;
    logic set_drop;
    logic out_load;
    logic cnt_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic match;
    logic cnt_zero;
    logic full;
    logic idx_last;
    logic out_free;
  } ctrl_sts_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_VAL    = 6'b000100,
    S_SCAN   = 6'b001000,
    S_APPEND = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_t;

endpackage

@@ src/sparse_row_product_accumulator_top.sv @@
// Row accumulator for a row-by-row sparse matrix product. An accumulate transaction
// multiplies its two weights (ordinary product, or the filter rule when the cfg_wr_data
// mode bit is set, in which case a zero result is dropped) and adds the result to the stored entry
// of the same column, or appends a new entry; a flush transaction streams the stored
// entries out in insertion order, marks the last one, and clears the row. A new column
// that finds the row full is dropped and flagged in overflow on every entry of the next
// flush; a flush of an empty row returns one entry with empty_res set. Entries live in
// a single RAM with one write and one registered read port, and the column search walks
// it one entry per cycle, so an accumulate stops at the first stored entry of its column
// or appends after the last one is examined, and a flush stalls while a loaded entry is
// not taken.
// The result register lets a new transaction be accepted while the last flushed entry
// waits to be taken.
module sparse_row_product_accumulator_top #(
  parameter int ROW_CAPACITY = srpa_pkg::ROW_CAPACITY_DEF,
  parameter int COLUMN_BITS  = srpa_pkg::COLUMN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srpa_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srpa_pkg::out_data_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  srpa_pkg::ctrl_cmd_t cmd;
  srpa_pkg::ctrl_sts_t sts;

  srpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_is_flush (in_data.cmd),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  srpa_dp #(
    .ROW_CAPACITY (ROW_CAPACITY),
    .COLUMN_BITS  (COLUMN_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`include "sparse_row_product_accumulator_top_assert.svh"

  `SRPA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `SRPA_ASSERT_NOW(a_empty_is_last, clk, rst_n, out_valid && out_data.empty_res, out_data.last)
  `SRPA_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && out_data.empty_res, out_data.out_weight == 32'sd0 && out_data.out_col == 16'd0)
  `SRPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

@@ src/srpa_ram.sv @@
module srpa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/srpa_ctrl.sv @@
module srpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_is_flush,
  output logic                in_ready,
  input  srpa_pkg::ctrl_sts_t sts,
  output srpa_pkg::ctrl_cmd_t cmd
);

  srpa_pkg::state_t state_r;
  srpa_pkg::state_t state_nxt;

  assign in_ready = (state_r == srpa_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      srpa_pkg::S_IDLE: begin
        cmd.idx_clr = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_is_flush == srpa_pkg::CMD_FLUSH) ? srpa_pkg::S_FLUSH
                                                             : srpa_pkg::S_MUL;
        end
      end
      srpa_pkg::S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = srpa_pkg::S_VAL;
      end
      srpa_pkg::S_VAL: begin
        cmd.val_en  = 1'b1;
        cmd.idx_clr = 1'b1;
        priority if (sts.skip) begin
          state_nxt = srpa_pkg::S_IDLE;
        end else if (sts.cnt_zero) begin
          state_nxt = srpa_pkg::S_APPEND;
        end else begin
          state_nxt = srpa_pkg::S_SCAN;
        end
      end
      srpa_pkg::S_SCAN: begin
        priority if (sts.match) begin
          cmd.wr_match = 1'b1;
          state_nxt    = srpa_pkg::S_IDLE;
        end else if (sts.idx_last) begin
          state_nxt = srpa_pkg::S_APPEND;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      srpa_pkg::S_APPEND: begin
        if (sts.full) begin
          cmd.set_drop = 1'b1;
        end else begin
          cmd.wr_append = 1'b1;
        end
        state_nxt = srpa_pkg::S_IDLE;
      end
      srpa_pkg::S_FLUSH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.cnt_zero || sts.idx_last) begin
            cmd.cnt_clear = 1'b1;
            state_nxt     = srpa_pkg::S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = srpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srpa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/srpa_dp.sv @@
module srpa_dp #(
  parameter int ROW_CAPACITY = srpa_pkg::ROW_CAPACITY_DEF,
  parameter int COLUMN_BITS  = srpa_pkg::COLUMN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srpa_pkg::in_data_t  in_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  srpa_pkg::ctrl_cmd_t cmd,
  output srpa_pkg::ctrl_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output srpa_pkg::out_data_t out_data
);

  localparam int AW   = $clog2(ROW_CAPACITY);
  localparam int CNTW = $clog2(ROW_CAPACITY + 1);
  localparam int CW   = COLUMN_BITS;
  localparam int RW   = CW + 32;

  logic                mode_r;
  logic signed [15:0]  a_r;
  logic signed [15:0]  b_r;
  logic [CW-1:0]       col_r;
  logic signed [31:0]  prod_r;
  logic signed [31:0]  val_r;
  logic [AW-1:0]       idx_r;
  logic [AW-1:0]       idx_nxt;
  logic [CNTW-1:0]     cnt_r;
  logic                drop_r;
  logic                out_valid_r;
  srpa_pkg::out_data_t out_data_r;

  logic [31:0]         in_col_ext;
  logic signed [31:0]  prod_c;
  logic signed [31:0]  val_c;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata;
  logic [RW-1:0]       ram_rdata;
  logic [CW-1:0]       rd_col;
  logic [31:0]         rd_col_ext;
  logic signed [31:0]  rd_w;
  logic signed [31:0]  sum_c;
  logic                empty_c;

  assign in_col_ext = {16'b0, in_data.b_col};
  assign prod_c     = a_r * b_r;

  always_comb begin
    if (mode_r == srpa_pkg::MODE_FILTER) begin
      priority if (a_r == 16'sd1 && b_r == 16'sd1) begin
        val_c = '0;
      end else if (a_r == 16'sd1) begin
        val_c = 32'(b_r);
      end else if (b_r == 16'sd1) begin
        val_c = 32'(a_r);
      end else begin
        val_c = -prod_r;
      end
    end else begin
      val_c = prod_r;
    end
  end

  assign rd_col     = ram_rdata[RW-1:32];
  assign rd_w       = ram_rdata[31:0];
  assign rd_col_ext = 32'(rd_col);
  assign sum_c      = rd_w + val_r;

  assign ram_we    = cmd.wr_match | cmd.wr_append;
  assign ram_waddr = cmd.wr_match ? idx_r : cnt_r[AW-1:0];
  assign ram_wdata = {col_r, (cmd.wr_match ? sum_c : val_r)};

  always_comb begin
    priority if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + AW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  srpa_ram #(
    .WIDTH (RW),
    .DEPTH (ROW_CAPACITY)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (idx_nxt),
    .rd_data (ram_rdata)
  );

  assign empty_c = (cnt_r == '0);

  assign sts.skip     = (mode_r == srpa_pkg::MODE_FILTER) && (val_c == '0);
  assign sts.match    = (rd_col == col_r);
  assign sts.cnt_zero = empty_c;
  assign sts.full     = (cnt_r == CNTW'(ROW_CAPACITY));
  assign sts.idx_last = ((CNTW'(idx_r) + CNTW'(1)) == cnt_r);
  assign sts.out_free = !out_valid_r || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= srpa_pkg::MODE_ORDINARY;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      priority if (cmd.cnt_clear) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end else if (cmd.wr_append) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (cmd.set_drop) begin
        drop_r <= 1'b1;
      end
      priority if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_in) begin
      a_r   <= in_data.a_weight;
      b_r   <= in_data.b_weight;
      col_r <= in_col_ext[CW-1:0];
    end
    if (cmd.mul_en) begin
      prod_r <= prod_c;
    end
    if (cmd.val_en) begin
      val_r <= val_c;
    end
    if (cmd.out_load) begin
      out_data_r.out_col    <= empty_c ? 16'd0 : rd_col_ext[15:0];
      out_data_r.out_weight <= empty_c ? 32'sd0 : rd_w;
      out_data_r.last       <= empty_c | sts.idx_last;
      out_data_r.empty_res  <= empty_c;
      out_data_r.overflow   <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ verif/sparse_row_product_accumulator_top_tb.sv @@
module sparse_row_product_accumulator_top_tb;
  import srpa_pkg::*;

  localparam int ROWS            = ROW_CAPACITY_DEF;
  localparam int SETTLE_CYCLES   = ROWS + 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 125;
  localparam int MAX_PRINTED     = 200;

  localparam int ROW_SHORT = 0;
  localparam int ROW_FILL  = 1;
  localparam int ROW_NOISE = 2;

  class row_scoreboard;
    logic [15:0] col_store[ROWS];
    logic [31:0] wt_store[ROWS];
    int unsigned n_entries;
    bit          dropped;
    logic        filter_mode;
    out_data_t   pending[$];
    int          errors;
    int          n_inputs;
    int          n_results;
    int          n_flushes;
    int          n_empty;
    int          n_overflow_rows;

    function void set_mode(logic m);
      filter_mode = m;
    endfunction

    function void note_input(in_data_t t);
      logic signed [31:0] a32;
      logic signed [31:0] b32;
      logic signed [31:0] prod;
      logic signed [31:0] val;
      out_data_t          r;
      bit                 hit;
      int                 k;
      n_inputs++;
      if (t.cmd == CMD_ACCUM) begin
        a32  = t.a_weight;
        b32  = t.b_weight;
        prod = a32 * b32;
        if (filter_mode == MODE_FILTER) begin
          if (a32 == 1 && b32 == 1) val = 0;
          else if (a32 == 1) val = b32;
          else if (b32 == 1) val = a32;
          else val = -prod;
          if (val == 0) return;
        end else begin
          val = prod;
        end
        hit = 0;
        for (k = 0; k < n_entries; k++) begin
          if (!hit && col_store[k] == t.b_col) begin
            wt_store[k] = wt_store[k] + val;
            hit = 1;
          end
        end
        if (!hit) begin
          if (n_entries < ROWS) begin
            col_store[n_entries] = t.b_col;
            wt_store[n_entries]  = val;
            n_entries++;
          end else begin
            dropped = 1;
          end
        end
      end else begin
        n_flushes++;
        if (dropped) n_overflow_rows++;
        if (n_entries == 0) begin
          r = '{out_col: '0, out_weight: '0, last: 1'b1, empty_res: 1'b1,
                overflow: dropped};
          pending = {pending, r};
          n_empty++;
        end else begin
          for (k = 0; k < n_entries; k++) begin
            r.out_col    = col_store[k];
            r.out_weight = wt_store[k];
            r.last       = (k == n_entries - 1);
            r.empty_res  = 1'b0;
            r.overflow   = dropped;
            pending = {pending, r};
          end
        end
        n_entries = 0;
        dropped   = 0;
      end
    endfunction

    task report(string what);
      errors++;
      // keep the log readable when the design is badly broken
      if (errors <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    task check_result(out_data_t got);
      out_data_t want;
      n_results++;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: col %0d weight %0d",
                         got.out_col, got.out_weight));
        return;
      end
      want = pending.pop_front();
      if (got.out_col !== want.out_col)
        report($sformatf("result %0d out_col %0d, want %0d", n_results,
                         got.out_col, want.out_col));
      if (got.out_weight !== want.out_weight)
        report($sformatf("result %0d out_weight %0d, want %0d", n_results,
                         got.out_weight, want.out_weight));
      if (got.last !== want.last)
        report($sformatf("result %0d last %b, want %b", n_results, got.last, want.last));
      if (got.empty_res !== want.empty_res)
        report($sformatf("result %0d empty_res %b, want %b", n_results,
                         got.empty_res, want.empty_res));
      if (got.overflow !== want.overflow)
        report($sformatf("result %0d overflow %b, want %b", n_results,
                         got.overflow, want.overflow));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_data_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_data_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  row_scoreboard row_sb;
  int  idle_cycles;
  int  next_gap;
  int  send_burst;
  int  phase_count;
  bit  hold_off_req;

  sparse_row_product_accumulator_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) row_sb.set_mode(cfg_wr_data);
      if (out_valid && out_ready) row_sb.check_result(out_data);
      if (in_valid && in_ready) row_sb.note_input(in_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles with no transaction", idle_cycles);
        $display("sparse_row_product_accumulator_top_tb: errors");
        $finish;
      end
    end
  end

  function automatic int draw_send_gap();
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(10, 40);
    return $urandom_range(0, 16);
  endfunction

  function automatic in_data_t make_item(logic cmd, logic signed [15:0] a,
                                         logic [15:0] col, logic signed [15:0] b);
    in_data_t t;
    t.cmd      = cmd;
    t.a_weight = a;
    t.b_col    = col;
    t.b_weight = b;
    return t;
  endfunction

  function automatic logic signed [15:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 16'sd1;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sh8000;
      4: return 16'sh7fff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_item(in_data_t t);
    if (next_gap > 0) begin
      in_valid <= 1'b0;
      repeat (next_gap) @(negedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    phase_count++;
    next_gap = draw_send_gap();
  endtask

  task automatic send_flush();
    send_item(make_item(CMD_FLUSH, 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
  endtask

  task automatic send_row(int kind);
    logic [15:0] base;
    logic [15:0] col;
    int          len;
    int          k;
    base = 16'($urandom_range(0, 65535));
    case (kind)
      ROW_FILL: begin
        len = ROWS + $urandom_range(2, 6);
        for (k = 0; k < len; k++)
          send_item(make_item(CMD_ACCUM, 16'($urandom_range(2, 65535)), base + k[15:0],
                              16'($urandom_range(2, 65535))));
        // matches after the row is full still accumulate
        for (k = 0; k < 3; k++)
          send_item(make_item(CMD_ACCUM, pick_weight(), 16'(base + $urandom_range(0, 7)),
                              pick_weight()));
      end
      ROW_SHORT: begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          col = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'(base + $urandom_range(0, 7));
          send_item(make_item(CMD_ACCUM, pick_weight(), col, pick_weight()));
        end
      end
      default: begin
        len = $urandom_range(0, 4);
        for (k = 0; k < len; k++)
          send_item(make_item(CMD_ACCUM, 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
        if ($urandom_range(0, 1)) send_flush();
      end
    endcase
    send_flush();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (row_sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // result side: random stalls, bursts of always-ready, one long hold-off on request
  initial begin
    int hold;
    int take_burst;
    take_burst = 0;
    out_ready  <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold = HOLD_OFF_CYCLES;
        hold_off_req = 0;
      end else if (take_burst > 0) begin
        hold = 0;
        take_burst--;
      end else begin
        if ($urandom_range(0, 15) == 0) take_burst = $urandom_range(10, 40);
        hold = $urandom_range(0, 16);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    int p;
    row_sb       = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 1'b0;
    next_gap     = 0;
    send_burst   = 0;
    hold_off_req = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ordinary products: empty row, extremes, wrap, zero-weight entries still match
    write_mode(MODE_ORDINARY);
    send_flush();
    send_item(make_item(CMD_ACCUM, 16'sh8000, 16'h0000, 16'sh8000));
    send_item(make_item(CMD_ACCUM, 16'sh7fff, 16'hffff, 16'sh8000));
    send_item(make_item(CMD_ACCUM, 16'sh8000, 16'h0000, 16'sh8000));
    send_item(make_item(CMD_ACCUM, 16'sh7fff, 16'h0000, 16'sh8000));
    send_item(make_item(CMD_ACCUM, 16'sd0, 16'h00aa, 16'sd123));
    send_item(make_item(CMD_ACCUM, 16'sd0, 16'h00aa, -16'sd5));
    send_item(make_item(CMD_ACCUM, 16'sd7, 16'h5555, 16'sd9));
    send_item(make_item(CMD_ACCUM, -16'sd1, 16'haaaa, 16'sd1));
    send_flush();
    drain();

    // filter rule: both one skipped, one side one, negated product, zero skipped
    write_mode(MODE_FILTER);
    send_item(make_item(CMD_ACCUM, 16'sd1, 16'h0003, 16'sd1));
    send_flush();
    send_item(make_item(CMD_ACCUM, 16'sd1, 16'h0003, -16'sd7));
    send_item(make_item(CMD_ACCUM, 16'sd300, 16'h0004, 16'sd1));
    send_item(make_item(CMD_ACCUM, -16'sd3, 16'h0003, 16'sd5));
    send_item(make_item(CMD_ACCUM, 16'sh8000, 16'h0009, 16'sh8000));
    send_item(make_item(CMD_ACCUM, 16'sd2, 16'h000a, 16'sd0));
    send_item(make_item(CMD_ACCUM, 16'sh7fff, 16'h0009, 16'sh7fff));
    send_item(make_item(CMD_ACCUM, -16'sd1, 16'h000b, -16'sd1));
    send_flush();
    drain();

    for (p = 0; p < 4; p++) begin
      write_mode((p % 2 == 0) ? MODE_FILTER : MODE_ORDINARY);
      if (p == 1) hold_off_req = 1;
      phase_count = 0;
      if (p < 2) send_row(ROW_FILL);
      while (phase_count < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0:       send_row(ROW_FILL);
          1, 2, 3: send_row(ROW_NOISE);
          default: send_row(ROW_SHORT);
        endcase
      end
      drain();
    end

    $display("%0d transactions in, %0d results out over %0d flushes in both modes",
             row_sb.n_inputs, row_sb.n_results, row_sb.n_flushes);
    $display("%0d empty rows, %0d rows with dropped columns, one %0d-cycle output stall",
             row_sb.n_empty, row_sb.n_overflow_rows, HOLD_OFF_CYCLES);
    if (row_sb.errors == 0) begin
      $display("sparse_row_product_accumulator_top_tb: clean");
    end else begin
      $display("%0d mismatches", row_sb.errors);
      $display("sparse_row_product_accumulator_top_tb: errors");
    end
    $finish;
  end

endmodule
